// ===== hdl/tsgd_pkg.sv =====
package tsgd_pkg;

	// action codes of one scan sample
	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_DOWN = 3'd1,
		ACT_KEEP = 3'd2,
		ACT_MOVE = 3'd3,
		ACT_UP   = 3'd4
	} action_t;

	// event codes
	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_SLIDE_UP   = 2'd1,
		EV_SLIDE_DOWN = 2'd2
	} event_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_START      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_END        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR_BIG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR_SMALL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 3'd5;

	// register reset values
	localparam logic [6:0]  VALID_START_RST    = 7'd0;
	localparam logic [6:0]  VALID_END_RST      = 7'd127;
	localparam logic [6:0]  MOVE_THR_BIG_RST   = 7'd8;
	localparam logic [6:0]  MOVE_THR_SMALL_RST = 7'd4;
	localparam logic [6:0]  MOVE_LIMIT_RST     = 7'd8;
	localparam logic [15:0] LONG_PRESS_RST     = 16'd100;

	// press tick counter saturation point
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

endpackage

// ===== hdl/touch_slider_gesture_detect.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_stall  | touch, position
// out      | output    | out_valid / out_stall| event_res, action, current_position,
//          |           |                      | anchor_position, move_distance
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one sample per cycle sustained while out_stall stays low; out_valid rises after a sample
// has passed the input register and then the state update into the result register
// arst_n clears the gesture state, the pipeline valids and loads the register defaults
// in_stall rises only while the input register is full and the result register is held
// by out_stall; cfg_ready is always high
module touch_slider_gesture_detect
	import tsgd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  touch,
	input  logic signed [7:0]     position,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            event_res,
	output logic [2:0]            action,
	output logic [6:0]            current_position,
	output logic [6:0]            anchor_position,
	output logic [6:0]            move_distance,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [6:0]  valid_start_q, valid_end_q, move_thr_big_q, move_thr_small_q, move_limit_q;
	logic [15:0] long_press_ticks_q;

	// gesture state
	action_t           prev_action_q;
	logic [6:0]        cur_pos_q, anchor_pos_q;
	logic signed [7:0] signed_distance_q;
	logic [15:0]       tick_count_q;
	logic              moving_q, long_pressed_q;
	event_t            last_direction_q, held_event_q;

	// input register
	logic              valid_s1;
	logic              touch_s1;
	logic signed [7:0] position_s1;

	// result register
	logic              out_valid_q;
	event_t            event_q;
	action_t           action_q;
	logic [6:0]        cur_pos_out_q, anchor_out_q, distance_out_q;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_start_q      <= VALID_START_RST;
			valid_end_q        <= VALID_END_RST;
			move_thr_big_q     <= MOVE_THR_BIG_RST;
			move_thr_small_q   <= MOVE_THR_SMALL_RST;
			move_limit_q       <= MOVE_LIMIT_RST;
			long_press_ticks_q <= LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VALID_START:      valid_start_q      <= cfg_data[6:0];
				REG_VALID_END:        valid_end_q        <= cfg_data[6:0];
				REG_MOVE_THR_BIG:     move_thr_big_q     <= cfg_data[6:0];
				REG_MOVE_THR_SMALL:   move_thr_small_q   <= cfg_data[6:0];
				REG_MOVE_LIMIT:       move_limit_q       <= cfg_data[6:0];
				REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			touch_s1    <= touch;
			position_s1 <= position;
		end
	end

	// next-state logic
	logic              in_window, idle;
	logic [6:0]        cur_n, anchor_det, anchor_n;
	logic signed [7:0] d, d_mod, lim, sd_n;
	logic [6:0]        d_mag, sd_mag;
	logic [15:0]       tick_n;
	logic              moving_n, long_n;
	action_t           act_n;
	event_t            ev_n, last_dir_n;

	always_comb begin
		in_window = touch_s1 && !position_s1[7] &&
			(position_s1[6:0] >= valid_start_q) && (position_s1[6:0] <= valid_end_q);
		idle  = (prev_action_q == ACT_NONE) || (prev_action_q == ACT_UP);
		cur_n = in_window ? position_s1[6:0] : cur_pos_q;

		d     = $signed({1'b0, cur_n}) - $signed({1'b0, anchor_pos_q});
		d_mag = d[7] ? 7'(-d) : d[6:0];
		lim   = $signed({1'b0, move_limit_q});

		act_n      = ACT_NONE;
		anchor_det = anchor_pos_q;
		tick_n     = tick_count_q;
		moving_n   = moving_q;
		last_dir_n = last_direction_q;
		sd_n       = signed_distance_q;
		d_mod      = d;

		// action detection
		if (idle && in_window) begin
			act_n      = ACT_DOWN;
			anchor_det = cur_n;
			tick_n     = '0;
		end else if (!idle && !in_window) begin
			act_n = ACT_UP;
		end else if (in_window) begin
			if (tick_count_q != TICK_MAX)
				tick_n = tick_count_q + 16'd1;
			if (!moving_q) begin
				if (d_mag >= move_thr_big_q) begin
					act_n      = ACT_MOVE;
					moving_n   = 1'b1;
					anchor_det = cur_n;
					d_mod      = d[7] ? -8'sd1 : ((d != 8'sd0) ? 8'sd1 : 8'sd0);
				end else begin
					act_n = ACT_KEEP;
				end
			end else if (d_mag >= move_thr_small_q) begin
				if ((d[7] && last_direction_q == EV_SLIDE_DOWN) ||
					(!d[7] && d != 8'sd0 && last_direction_q == EV_SLIDE_UP)) begin
					act_n      = ACT_KEEP;
					last_dir_n = EV_NONE;
				end else begin
					act_n = ACT_MOVE;
				end
			end else begin
				act_n = ACT_KEEP;
			end
			// clamp to the move limit
			if (d_mod > lim)
				sd_n = lim;
			else if (d_mod < -lim)
				sd_n = -lim;
			else
				sd_n = d_mod;
		end

		// event analysis
		long_n = long_pressed_q;
		if (act_n == ACT_UP && !moving_n) begin
			ev_n = held_event_q;
		end else if (act_n == ACT_KEEP && !long_pressed_q && !moving_n &&
			tick_n >= long_press_ticks_q) begin
			long_n = 1'b1;
			ev_n   = held_event_q;
		end else if (act_n == ACT_MOVE && !long_pressed_q) begin
			ev_n       = sd_n[7] ? EV_SLIDE_UP : EV_SLIDE_DOWN;
			last_dir_n = ev_n;
		end else begin
			ev_n = EV_NONE;
		end

		sd_mag   = sd_n[7] ? 7'(-sd_n) : sd_n[6:0];
		anchor_n = (ev_n == EV_SLIDE_UP || ev_n == EV_SLIDE_DOWN) ? cur_n : anchor_det;
	end

	// gesture state update, cleared on release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_action_q     <= ACT_NONE;
			cur_pos_q         <= '0;
			anchor_pos_q      <= '0;
			signed_distance_q <= '0;
			tick_count_q      <= '0;
			moving_q          <= 1'b0;
			long_pressed_q    <= 1'b0;
			last_direction_q  <= EV_NONE;
			held_event_q      <= EV_NONE;
		end else if (advance) begin
			if (act_n == ACT_UP) begin
				prev_action_q     <= ACT_NONE;
				cur_pos_q         <= '0;
				anchor_pos_q      <= '0;
				signed_distance_q <= '0;
				tick_count_q      <= '0;
				moving_q          <= 1'b0;
				long_pressed_q    <= 1'b0;
				last_direction_q  <= EV_NONE;
				held_event_q      <= EV_NONE;
			end else begin
				prev_action_q     <= act_n;
				cur_pos_q         <= cur_n;
				anchor_pos_q      <= anchor_n;
				signed_distance_q <= sd_n;
				tick_count_q      <= tick_n;
				moving_q          <= moving_n;
				long_pressed_q    <= long_n;
				last_direction_q  <= last_dir_n;
				held_event_q      <= ev_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q        <= ev_n;
			action_q       <= act_n;
			cur_pos_out_q  <= cur_n;
			anchor_out_q   <= anchor_det;
			distance_out_q <= sd_mag;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_res        = event_q;
	assign action           = action_q;
	assign current_position = cur_pos_out_q;
	assign anchor_position  = anchor_out_q;
	assign move_distance    = distance_out_q;

endmodule
